### hdl/hec_pkg.sv
// hec_pkg: widths, request codes, stage structs and helper functions
// for the hamming encode and check pipeline; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package hec_pkg;

  localparam int MAX_DATA_BITS = 57;
  localparam int CW_BITS       = 63;
  localparam int SYN_BITS      = 6;
  localparam int LEN_BITS      = 6;
  localparam int GROUP_BITS    = 16;
  localparam int GROUPS        = (CW_BITS + GROUP_BITS) / GROUP_BITS;

  localparam logic [LEN_BITS-1:0] DATA_LEN_RESET = LEN_BITS'(MAX_DATA_BITS);

  localparam logic REQ_ENCODE = 1'b0;
  localparam logic REQ_CHECK  = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic [CW_BITS-1:0] word;
  } front_t;

  typedef struct packed {
    logic                             req_type;
    logic [CW_BITS-1:0]               word;
    logic [SYN_BITS-1:0][GROUPS-1:0]  part;
  } mid_t;

  typedef struct packed {
    logic [CW_BITS-1:0]  codeword_out;
    logic [SYN_BITS-1:0] syndrome;
    logic                error_found;
  } rsp_t;

  // clamp the length register to the legal range
  function automatic logic [LEN_BITS-1:0] eff_len(input logic [LEN_BITS-1:0] dl);
    logic [LEN_BITS-1:0] n;
    n = dl;
    if (dl == '0) n = LEN_BITS'(1);
    if (dl > LEN_BITS'(MAX_DATA_BITS)) n = LEN_BITS'(MAX_DATA_BITS);
    return n;
  endfunction

  function automatic logic [2:0] parity_count(input logic [LEN_BITS-1:0] n);
    logic [2:0] p;
    p = 3'd1;
    for (int k = 1; k < 7; k++) begin
      if (p == 3'(k) && (8'd1 << k) < (8'(n) + 8'(k) + 8'd1)) p = 3'(k + 1);
    end
    return p;
  endfunction

  // position (from 1) of data bit j: the j-th position that is not a power of two
  function automatic int data_pos(input int j);
    int c;
    int pos;
    c   = 0;
    pos = 0;
    for (int q = 1; q <= CW_BITS; q++) begin
      if ((q & (q - 1)) != 0) begin
        if (c == j) pos = q;
        c++;
      end
    end
    return pos;
  endfunction

endpackage
`default_nettype wire

### hdl/hec_ifs.sv
// channel interfaces for the hamming encode and check block
// depends on hec_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none
interface hec_req_if;
  logic                                valid;
  logic                                ready;
  logic                                req_type;
  logic [hec_pkg::MAX_DATA_BITS-1:0]   data_word;
  logic [hec_pkg::CW_BITS-1:0]         codeword_in;
  modport source (output valid, req_type, data_word, codeword_in, input ready);
  modport sink   (input valid, req_type, data_word, codeword_in, output ready);
endinterface

interface hec_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [hec_pkg::CW_BITS-1:0]   codeword_out;
  logic [hec_pkg::SYN_BITS-1:0]  syndrome;
  logic                          error_found;
  modport source (output valid, codeword_out, syndrome, error_found, input ready);
  modport sink   (input valid, codeword_out, syndrome, error_found, output ready);
endinterface

interface hec_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [hec_pkg::LEN_BITS-1:0]  data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

### hdl/hec_front.sv
// first stage: length masks and scatter of data bits to codeword positions
// depends on hec_pkg
`timescale 1ns / 1ps
`default_nettype none
module hec_front (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic [hec_pkg::LEN_BITS-1:0]      data_len,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              req_type,
  input  wire logic [hec_pkg::MAX_DATA_BITS-1:0] data_word,
  input  wire logic [hec_pkg::CW_BITS-1:0]       codeword_in,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output hec_pkg::front_t                        out_data
);

  logic [hec_pkg::LEN_BITS-1:0]      n;
  logic [hec_pkg::LEN_BITS-1:0]      total;
  logic [hec_pkg::MAX_DATA_BITS-1:0] dmask;
  logic [hec_pkg::CW_BITS-1:0]       cmask;
  logic [hec_pkg::CW_BITS-1:0]       enc;
  hec_pkg::front_t                   front_next;

  assign n     = hec_pkg::eff_len(data_len);
  assign total = n + hec_pkg::LEN_BITS'(hec_pkg::parity_count(n));

  always_comb begin
    for (int j = 0; j < hec_pkg::MAX_DATA_BITS; j++) begin
      dmask[j] = hec_pkg::LEN_BITS'(j) < n;
    end
    for (int q = 1; q <= hec_pkg::CW_BITS; q++) begin
      cmask[q-1] = hec_pkg::LEN_BITS'(q) <= total;
    end
    enc = '0;
    for (int j = 0; j < hec_pkg::MAX_DATA_BITS; j++) begin
      enc[hec_pkg::LEN_BITS'(hec_pkg::data_pos(j) - 1)] = data_word[j] & dmask[j];
    end
    front_next.req_type = req_type;
    front_next.word     = (req_type == hec_pkg::REQ_CHECK) ? (codeword_in & cmask) : enc;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= front_next;
    end
  end

endmodule
`default_nettype wire

### hdl/hec_parity.sv
// second stage: per syndrome bit partial parities over groups of positions
// depends on hec_pkg
`timescale 1ns / 1ps
`default_nettype none
module hec_parity (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire hec_pkg::front_t in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output hec_pkg::mid_t   out_data
);

  hec_pkg::mid_t mid_next;

  always_comb begin
    mid_next.req_type = in_data.req_type;
    mid_next.word     = in_data.word;
    mid_next.part     = '0;
    for (int k = 0; k < hec_pkg::SYN_BITS; k++) begin
      for (int g = 0; g < hec_pkg::GROUPS; g++) begin
        for (int b = 0; b < hec_pkg::GROUP_BITS; b++) begin
          if (g * hec_pkg::GROUP_BITS + b < hec_pkg::CW_BITS &&
              (((g * hec_pkg::GROUP_BITS + b + 1) >> k) & 1) == 1) begin
            mid_next.part[k][g] = mid_next.part[k][g] ^
                                  in_data.word[g * hec_pkg::GROUP_BITS + b];
          end
        end
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= mid_next;
    end
  end

endmodule
`default_nettype wire

### hdl/hec_final.sv
// third stage: syndrome reduction, parity insertion and output register
// depends on hec_pkg
`timescale 1ns / 1ps
`default_nettype none
module hec_final (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire hec_pkg::mid_t in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output hec_pkg::rsp_t out_data
);

  logic [hec_pkg::SYN_BITS-1:0] syn;
  logic [hec_pkg::CW_BITS-1:0]  cw;
  hec_pkg::rsp_t                rsp_next;

  always_comb begin
    for (int k = 0; k < hec_pkg::SYN_BITS; k++) begin
      syn[k] = ^in_data.part[k];
    end
    cw = in_data.word;
    // parity bits sit at positions 2^k
    for (int k = 0; k < hec_pkg::SYN_BITS; k++) begin
      cw[(1 << k) - 1] = syn[k];
    end
    if (in_data.req_type == hec_pkg::REQ_CHECK) begin
      rsp_next.codeword_out = '0;
      rsp_next.syndrome     = syn;
      rsp_next.error_found  = syn != '0;
    end else begin
      rsp_next.codeword_out = cw;
      rsp_next.syndrome     = '0;
      rsp_next.error_found  = 1'b0;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= rsp_next;
    end
  end

endmodule
`default_nettype wire

### hdl/hamming_encode_and_check.sv
// hamming encode and check block, top level
// one beat per cycle while the response side is not stalled
// three register stages: scatter and mask, partial parities, syndrome and output
// a stalled response holds the last stage and the full stages directly behind it; empty stages keep accepting
// reset (rst, synchronous) empties all stages and sets data_len to 57
// depends on hec_pkg, hec_ifs, hec_front, hec_parity, hec_final
`timescale 1ns / 1ps
`default_nettype none
module hamming_encode_and_check (
  input  wire logic clk,
  input  wire logic rst,
  hec_cfg_if.sink   cfg,
  hec_req_if.sink   req,
  hec_rsp_if.source rsp
);

  logic [hec_pkg::LEN_BITS-1:0] data_len;
  logic                         v1;
  logic                         r1;
  hec_pkg::front_t              d1;
  logic                         v2;
  logic                         r2;
  hec_pkg::mid_t                d2;
  hec_pkg::rsp_t                d3;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      data_len <= hec_pkg::DATA_LEN_RESET;
    end else if (cfg.valid && cfg.ready) begin
      data_len <= cfg.data;
    end
  end

  hec_front u_front (
    .clk         (clk),
    .rst         (rst),
    .data_len    (data_len),
    .in_valid    (req.valid),
    .in_ready    (req.ready),
    .req_type    (req.req_type),
    .data_word   (req.data_word),
    .codeword_in (req.codeword_in),
    .out_valid   (v1),
    .out_ready   (r1),
    .out_data    (d1)
  );

  hec_parity u_parity (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v1),
    .in_ready  (r1),
    .in_data   (d1),
    .out_valid (v2),
    .out_ready (r2),
    .out_data  (d2)
  );

  hec_final u_final (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v2),
    .in_ready  (r2),
    .in_data   (d2),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_data  (d3)
  );

  assign rsp.codeword_out = d3.codeword_out;
  assign rsp.syndrome     = d3.syndrome;
  assign rsp.error_found  = d3.error_found;

endmodule
`default_nettype wire

### hdl/hec_checker.sv
// port-level assertions for hamming_encode_and_check, attached by bind
// depends on hec_pkg for widths
`timescale 1ns / 1ps
`default_nettype none
module hec_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         req_ready,
  input wire logic                         rsp_valid,
  input wire logic                         rsp_ready,
  input wire logic [hec_pkg::CW_BITS-1:0]  codeword_out,
  input wire logic [hec_pkg::SYN_BITS-1:0] syndrome,
  input wire logic                         error_found
);

  // back pressure reaches the request side only when the response beat is stuck
  assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> (rsp_valid && !rsp_ready))
    else $error("request side stalled while response side free");

  assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response beat right after reset");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response beat dropped under stall");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=>
      $stable(codeword_out) && $stable(syndrome) && $stable(error_found))
    else $error("response payload changed under stall");

endmodule

bind hamming_encode_and_check hec_checker u_hec_checker (
  .clk          (clk),
  .rst          (rst),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .codeword_out (rsp.codeword_out),
  .syndrome     (rsp.syndrome),
  .error_found  (rsp.error_found)
);
`default_nettype wire
